### hw/rtl/ordered_segment_scatter_mapper_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ordered segment scatter mapper
// Implication checks sampled on the rising clock edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef ORDERED_SEGMENT_SCATTER_MAPPER_UNIT_ASSERT_SVH
`define ORDERED_SEGMENT_SCATTER_MAPPER_UNIT_ASSERT_SVH

// same-cycle implication
`define OSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/osm_pkg.sv
// ----------------------------------------------------------------------------
// osm_pkg
// Shared types and constants of the ordered segment scatter mapper.
// ----------------------------------------------------------------------------
package osm_pkg;

    localparam int unsigned DEF_TABLE_DEPTH = 16;

    localparam int unsigned FUNC_W = 2;
    localparam int unsigned VOFF_W = 48;
    localparam int unsigned LEN_W  = 32;
    localparam int unsigned COFF_W = 48;
    localparam int unsigned ADDR_W = 64;
    localparam int unsigned TOT_W  = 37;
    localparam int unsigned STAT_W = 3;

    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INGEST = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FINAL  = 2'd2;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 3'd0,
        ST_FINALIZED  = 3'd1,
        ST_EXCEEDS    = 3'd2,
        ST_OVERLAP    = 3'd3,
        ST_GAP        = 3'd4,
        ST_INCOMPLETE = 3'd5,
        ST_TABLE_FULL = 3'd6
    } t_status;

    // one descriptor table entry
    typedef struct packed {
        logic [VOFF_W-1:0] view_start;
        logic [LEN_W-1:0]  length;
        logic [COFF_W-1:0] dest_off;
        logic [LEN_W-1:0]  written;
    } t_desc;

    // one result item
    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] dest;
        logic [LEN_W-1:0]  plen;
        logic [LEN_W-1:0]  soff;
        logic              last;
    } t_result;

endpackage

### hw/rtl/osm_desc_ram.sv
// ----------------------------------------------------------------------------
// osm_desc_ram
// Descriptor table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module osm_desc_ram #(
    parameter int unsigned DEPTH = osm_pkg::DEF_TABLE_DEPTH,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic           i_clk,
    input  logic           i_wr_en,
    input  logic [AW-1:0]  i_wr_addr,
    input  osm_pkg::t_desc i_wr_data,
    input  logic           i_rd_en,
    input  logic [AW-1:0]  i_rd_addr,
    output osm_pkg::t_desc o_rd_data
);

    osm_pkg::t_desc mem [DEPTH];
    osm_pkg::t_desc r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

### hw/rtl/osm_walker.sv
// ----------------------------------------------------------------------------
// osm_walker
// Command decode and descriptor walk: reads one entry per cycle while i_slot_free
// is high, splits the segment into pieces and writes the updated written count back.
// ----------------------------------------------------------------------------
`include "ordered_segment_scatter_mapper_unit_assert.svh"

module osm_walker #(
    parameter int unsigned DEPTH = osm_pkg::DEF_TABLE_DEPTH,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int unsigned IW    = $clog2(DEPTH + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [osm_pkg::FUNC_W-1:0]   i_func,
    input  logic [osm_pkg::VOFF_W-1:0]   i_voff,
    input  logic [osm_pkg::LEN_W-1:0]    i_len,
    input  logic [osm_pkg::COFF_W-1:0]   i_coff,
    input  logic [osm_pkg::ADDR_W-1:0]   i_base,
    input  logic                         i_slot_free,
    output logic                         o_res_valid,
    output osm_pkg::t_result             o_res,
    output logic                         o_rd_en,
    output logic [AW-1:0]                o_rd_addr,
    input  osm_pkg::t_desc               i_rd_data,
    output logic                         o_wr_en,
    output logic [AW-1:0]                o_wr_addr,
    output osm_pkg::t_desc               o_wr_data
);

    localparam logic [IW-1:0] DEPTH_L = IW'(DEPTH);
    localparam logic [IW-1:0] ONE_L   = IW'(1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROC,
        S_ERR
    } t_state;

    t_state                     r_state, n_state;
    logic [IW-1:0]              r_entry_count, n_entry_count;
    logic [IW-1:0]              r_cur_idx, n_cur_idx;
    logic [osm_pkg::TOT_W-1:0]  r_planned, n_planned;
    logic [osm_pkg::TOT_W-1:0]  r_ing, n_ing;
    logic                       r_final, n_final;
    logic [IW-1:0]              r_idx, n_idx;
    logic [osm_pkg::VOFF_W-1:0] r_voff, n_voff;
    logic [osm_pkg::LEN_W-1:0]  r_total, n_total;
    logic [osm_pkg::LEN_W-1:0]  r_proc, n_proc;

    logic                       accept;
    logic                       idx_oob;
    logic [osm_pkg::VOFF_W:0]   expected, absolute;
    logic [osm_pkg::LEN_W-1:0]  rem_desc, rem_data, step, new_wr;
    logic [osm_pkg::TOT_W-1:0]  new_ing;
    logic                       ovf, fin, desc_full, pos_ok;
    logic [IW-1:0]              idx_inc;
    logic [osm_pkg::ADDR_W-1:0] dest;
    osm_pkg::t_desc             q;

    assign q          = i_rd_data;
    assign o_in_ready = (r_state == S_IDLE) && i_slot_free;
    assign accept     = i_in_valid && o_in_ready;

    // per-descriptor step, from the table entry read most recently
    assign idx_oob   = r_idx >= r_entry_count;
    assign expected  = {1'b0, q.view_start} + (osm_pkg::VOFF_W + 1)'(q.written);
    assign absolute  = {1'b0, r_voff} + (osm_pkg::VOFF_W + 1)'(r_proc);
    assign pos_ok    = absolute == expected;
    assign rem_desc  = q.length - q.written;
    assign rem_data  = r_total - r_proc;
    assign step      = (rem_desc < rem_data) ? rem_desc : rem_data;
    assign fin       = step == rem_data;
    assign new_wr    = q.written + step;
    assign desc_full = new_wr == q.length;
    assign new_ing   = r_ing + osm_pkg::TOT_W'(step);
    assign ovf       = new_ing > r_planned;
    assign idx_inc   = r_idx + ONE_L;
    assign dest      = i_base + osm_pkg::ADDR_W'(q.dest_off) + osm_pkg::ADDR_W'(q.written);

    always_comb begin
        n_state       = r_state;
        n_entry_count = r_entry_count;
        n_cur_idx     = r_cur_idx;
        n_planned     = r_planned;
        n_ing         = r_ing;
        n_final       = r_final;
        n_idx         = r_idx;
        n_voff        = r_voff;
        n_total       = r_total;
        n_proc        = r_proc;

        o_res_valid   = 1'b0;
        o_res.status  = osm_pkg::ST_OK;
        o_res.dest    = '0;
        o_res.plen    = '0;
        o_res.soff    = '0;
        o_res.last    = 1'b1;

        o_rd_en       = 1'b0;
        o_rd_addr     = idx_inc[AW-1:0];
        o_wr_en       = 1'b0;
        o_wr_addr     = r_idx[AW-1:0];
        o_wr_data     = q;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_func)
                        osm_pkg::FUNC_LOAD: begin
                            o_res_valid = 1'b1;
                            if (r_final) begin
                                o_res.status = osm_pkg::ST_FINALIZED;
                            end else if (r_entry_count >= DEPTH_L) begin
                                o_res.status = osm_pkg::ST_TABLE_FULL;
                            end else begin
                                o_wr_en              = 1'b1;
                                o_wr_addr            = r_entry_count[AW-1:0];
                                o_wr_data.view_start = i_voff;
                                o_wr_data.length     = i_len;
                                o_wr_data.dest_off   = i_coff;
                                o_wr_data.written    = '0;
                                n_entry_count        = r_entry_count + ONE_L;
                                n_planned            = r_planned + osm_pkg::TOT_W'(i_len);
                            end
                        end
                        osm_pkg::FUNC_INGEST: begin
                            if (r_final) begin
                                o_res_valid  = 1'b1;
                                o_res.status = osm_pkg::ST_FINALIZED;
                            end else if (i_len == '0) begin
                                o_res_valid  = 1'b1;
                            end else if (r_cur_idx >= r_entry_count) begin
                                o_res_valid  = 1'b1;
                                o_res.status = osm_pkg::ST_EXCEEDS;
                            end else begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = r_cur_idx[AW-1:0];
                                n_idx     = r_cur_idx;
                                n_voff    = i_voff;
                                n_total   = i_len;
                                n_proc    = '0;
                                n_state   = S_PROC;
                            end
                        end
                        osm_pkg::FUNC_FINAL: begin
                            o_res_valid = 1'b1;
                            if (r_final) begin
                                o_res.status = osm_pkg::ST_FINALIZED;
                            end else if (r_ing != r_planned) begin
                                o_res.status = osm_pkg::ST_INCOMPLETE;
                            end else begin
                                n_final = 1'b1;
                            end
                        end
                        default: begin
                            // unused code: no result, no change
                        end
                    endcase
                end
            end
            S_PROC: begin
                if (i_slot_free) begin
                    if (idx_oob) begin
                        o_res_valid  = 1'b1;
                        o_res.status = osm_pkg::ST_EXCEEDS;
                        n_state      = S_IDLE;
                    end else if (!pos_ok) begin
                        o_res_valid  = 1'b1;
                        o_res.status = (absolute < expected) ? osm_pkg::ST_OVERLAP
                                                             : osm_pkg::ST_GAP;
                        n_state      = S_IDLE;
                    end else begin
                        o_wr_en           = 1'b1;
                        o_wr_data.written = new_wr;
                        n_ing             = new_ing;
                        n_proc            = r_proc + step;
                        if (step != '0) begin
                            o_res_valid = 1'b1;
                            o_res.dest  = dest;
                            o_res.plen  = step;
                            o_res.soff  = r_proc;
                            o_res.last  = fin && !ovf;
                        end
                        if (ovf) begin
                            // plan overrun: error item follows the piece, or stands alone if the step is empty
                            if (step != '0) begin
                                n_state = S_ERR;
                            end else begin
                                o_res_valid  = 1'b1;
                                o_res.status = osm_pkg::ST_EXCEEDS;
                                n_state      = S_IDLE;
                            end
                        end else if (fin) begin
                            n_cur_idx = desc_full ? idx_inc : r_idx;
                            n_state   = S_IDLE;
                        end else begin
                            // descriptor filled, prefetch the next one
                            n_idx   = idx_inc;
                            o_rd_en = 1'b1;
                        end
                    end
                end
            end
            S_ERR: begin
                if (i_slot_free) begin
                    o_res_valid  = 1'b1;
                    o_res.status = osm_pkg::ST_EXCEEDS;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_entry_count <= '0;
            r_cur_idx     <= '0;
            r_planned     <= '0;
            r_ing         <= '0;
            r_final       <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_entry_count <= n_entry_count;
            r_cur_idx     <= n_cur_idx;
            r_planned     <= n_planned;
            r_ing         <= n_ing;
            r_final       <= n_final;
        end
        r_idx   <= n_idx;
        r_voff  <= n_voff;
        r_total <= n_total;
        r_proc  <= n_proc;
    end

    `OSM_ASSERT_IMP(a_no_push_when_full, i_clk, i_rst_n, o_res_valid, i_slot_free, "result pushed into a full output register")
    `OSM_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_entry_count <= DEPTH_L, "entry count beyond table depth")
    `OSM_ASSERT_IMP(a_cur_idx_bound, i_clk, i_rst_n, r_state == S_IDLE, r_cur_idx <= r_entry_count, "current index past loaded entries")
    `OSM_ASSERT_IMP(a_piece_nonzero, i_clk, i_rst_n, (r_state == S_PROC) && o_res_valid && (o_res.status == osm_pkg::ST_OK), o_res.plen != '0, "empty piece emitted")
    `OSM_ASSERT_NXT(a_ovf_to_err, i_clk, i_rst_n, (r_state == S_PROC) && i_slot_free && !idx_oob && pos_ok && ovf && (step != '0), r_state == S_ERR, "plan overrun without error item")

endmodule

### hw/rtl/ordered_segment_scatter_mapper_unit.sv
// Load, finalize: result in the output register in the cycle after accept.
// Ingest: the descriptor read is registered, then S_PROC checks one table entry per cycle
// (running off the loaded entries counts as one), and S_ERR follows when the plan is overrun
// after a piece; a full output register with m_axis_tready low stalls the walk.
// Reset (synchronous, i_rst_n low) clears counts, totals, finalized flag and output
// valid; table entries hold no reset value and are written when loaded.
// ----------------------------------------------------------------------------
// ordered_segment_scatter_mapper_unit
// Scatter-gather descriptor walk: loads descriptors, maps ordered segments
// onto destination pieces, checks ordering and completion.
// ----------------------------------------------------------------------------
module ordered_segment_scatter_mapper_unit #(
    parameter int unsigned TABLE_DEPTH = osm_pkg::DEF_TABLE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [63:0]  i_cfg_data,      // base_address
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,    // seg_start[47:0], length[79:48],
                                          // dest_off[127:80]
    input  logic [7:0]   s_axis_tuser,    // func[1:0], zero above
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,    // dest_address[63:0], piece_length[95:64],
                                          // segment_offset[127:96]
    output logic [7:0]   m_axis_tuser,    // status[2:0], zero above
    output logic         m_axis_tlast
);

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned IW = $clog2(TABLE_DEPTH + 1);

    logic [osm_pkg::ADDR_W-1:0] r_base;
    logic                       r_ovalid;
    osm_pkg::t_result           r_out;

    logic                       slot_free;
    logic                       res_valid;
    osm_pkg::t_result           res;
    logic                       rd_en, wr_en;
    logic [AW-1:0]              rd_addr, wr_addr;
    osm_pkg::t_desc             rd_data, wr_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_cfg_valid) begin
            r_base <= i_cfg_data;
        end
    end

    // output register; refilled in the cycle it is drained
    assign slot_free = !r_ovalid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_valid) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_out.soff, r_out.plen, r_out.dest};
    assign m_axis_tuser  = {5'b0, r_out.status};
    assign m_axis_tlast  = r_out.last;

    osm_walker #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .IW    (IW)
    ) u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_func      (s_axis_tuser[1:0]),
        .i_voff      (s_axis_tdata[47:0]),
        .i_len       (s_axis_tdata[79:48]),
        .i_coff      (s_axis_tdata[127:80]),
        .i_base      (r_base),
        .i_slot_free (slot_free),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    osm_desc_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_desc_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for ordered_segment_scatter_mapper_unit
// Loads a contiguous descriptor chain, feeds in-order and out-of-order
// segments, and checks every piece and status against an in-bench model of
// the descriptor walk. Covers base address wrap, empty descriptors, overrun,
// gap/overlap after pieces, a full table and finalize.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [osm_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int unsigned       WATCHDOG_LIMIT = 2000;
    localparam int unsigned       SETTLE_CYCLES = 24;

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [63:0]  i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;    // seg_start[47:0], length[79:48],
                                   // dest_off[127:80]
    logic [7:0]   s_axis_tuser;    // func[1:0], zero above
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;    // dest_address[63:0], piece_length[95:64],
                                   // segment_offset[127:96]
    logic [7:0]   m_axis_tuser;    // status[2:0], zero above
    logic         m_axis_tlast;

    ordered_segment_scatter_mapper_unit #(
        .TABLE_DEPTH(osm_pkg::DEF_TABLE_DEPTH)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mirror of the block state
    bit [osm_pkg::VOFF_W-1:0] tbl_view [osm_pkg::DEF_TABLE_DEPTH];
    bit [osm_pkg::LEN_W-1:0]  tbl_len  [osm_pkg::DEF_TABLE_DEPTH];
    bit [osm_pkg::COFF_W-1:0] tbl_dest [osm_pkg::DEF_TABLE_DEPTH];
    bit [osm_pkg::LEN_W-1:0]  tbl_done [osm_pkg::DEF_TABLE_DEPTH];
    int unsigned              n_entries;
    int unsigned              walk_idx;
    bit [osm_pkg::TOT_W-1:0]  plan_bytes;
    bit [osm_pkg::TOT_W-1:0]  seen_bytes;
    bit                       closed;
    bit [osm_pkg::ADDR_W-1:0] base_addr;

    osm_pkg::t_result expected_pieces [$];
    int unsigned      error_count;
    int unsigned      results_checked;
    int unsigned      n_load, n_ingest, n_final, n_unused;
    int unsigned      quiet_cycles = 0;
    bit               feed_gaps;
    bit               drain_gaps;

    function automatic osm_pkg::t_result status_only(osm_pkg::t_status st);
        osm_pkg::t_result r;
        r = '0;
        r.status = st;
        r.last = 1'b1;
        return r;
    endfunction

    // expected results of one accepted item; updates the mirrored state
    function automatic void predict_mapping(logic [osm_pkg::FUNC_W-1:0] fn,
                                            logic [osm_pkg::VOFF_W-1:0] voff,
                                            logic [osm_pkg::LEN_W-1:0] len,
                                            logic [osm_pkg::COFF_W-1:0] coff);
        osm_pkg::t_result out [$];
        osm_pkg::t_result r;
        int unsigned      idx;
        bit               failed;
        logic [63:0]      done, expect_pos, at, rem_desc, rem_data, step;
        case (fn)
            osm_pkg::FUNC_LOAD: begin
                if (closed) begin
                    out = {out, status_only(osm_pkg::ST_FINALIZED)};
                end else if (n_entries >= osm_pkg::DEF_TABLE_DEPTH) begin
                    out = {out, status_only(osm_pkg::ST_TABLE_FULL)};
                end else begin
                    tbl_view[n_entries] = voff;
                    tbl_len[n_entries] = len;
                    tbl_dest[n_entries] = coff;
                    tbl_done[n_entries] = '0;
                    n_entries++;
                    plan_bytes = plan_bytes + osm_pkg::TOT_W'(len);
                    out = {out, status_only(osm_pkg::ST_OK)};
                end
            end
            osm_pkg::FUNC_INGEST: begin
                if (closed) begin
                    out = {out, status_only(osm_pkg::ST_FINALIZED)};
                end else if (len == 0) begin
                    out = {out, status_only(osm_pkg::ST_OK)};
                end else if (walk_idx >= n_entries) begin
                    out = {out, status_only(osm_pkg::ST_EXCEEDS)};
                end else begin
                    idx = walk_idx;
                    done = '0;
                    failed = 1'b0;
                    while (done < 64'(len) && !failed) begin
                        if (idx >= n_entries) begin
                            out = {out, status_only(osm_pkg::ST_EXCEEDS)};
                            failed = 1'b1;
                        end else begin
                            expect_pos = 64'(tbl_view[idx]) + 64'(tbl_done[idx]);
                            at = 64'(voff) + done;
                            if (at < expect_pos) begin
                                out = {out, status_only(osm_pkg::ST_OVERLAP)};
                                failed = 1'b1;
                            end else if (at > expect_pos) begin
                                out = {out, status_only(osm_pkg::ST_GAP)};
                                failed = 1'b1;
                            end else begin
                                rem_desc = 64'(tbl_len[idx]) - 64'(tbl_done[idx]);
                                rem_data = 64'(len) - done;
                                step = (rem_desc < rem_data) ? rem_desc : rem_data;
                                if (step != 0) begin
                                    r = '0;
                                    r.status = osm_pkg::ST_OK;
                                    r.dest = base_addr + 64'(tbl_dest[idx]) +
                                             64'(tbl_done[idx]);
                                    r.plen = step[osm_pkg::LEN_W-1:0];
                                    r.soff = done[osm_pkg::LEN_W-1:0];
                                    r.last = ((done + step) == 64'(len));
                                    out = {out, r};
                                end
                                tbl_done[idx] = tbl_done[idx] + step[osm_pkg::LEN_W-1:0];
                                done = done + step;
                                seen_bytes = seen_bytes + step[osm_pkg::TOT_W-1:0];
                                if (seen_bytes > plan_bytes) begin
                                    if (out.size() > 0)
                                        out[out.size()-1].last = 1'b0;
                                    out = {out, status_only(osm_pkg::ST_EXCEEDS)};
                                    failed = 1'b1;
                                end else if (tbl_done[idx] == tbl_len[idx]) begin
                                    idx++;
                                end
                            end
                        end
                    end
                    // an error leaves the walk position where it was
                    if (!failed)
                        walk_idx = idx;
                end
            end
            osm_pkg::FUNC_FINAL: begin
                if (closed)
                    out = {out, status_only(osm_pkg::ST_FINALIZED)};
                else if (seen_bytes != plan_bytes)
                    out = {out, status_only(osm_pkg::ST_INCOMPLETE)};
                else begin
                    closed = 1'b1;
                    out = {out, status_only(osm_pkg::ST_OK)};
                end
            end
            default: ;
        endcase
        expected_pieces = {expected_pieces, out};
    endfunction

    function automatic logic [63:0] chain_end();
        if (n_entries == 0)
            return '0;
        return 64'(tbl_view[n_entries-1]) + 64'(tbl_len[n_entries-1]);
    endfunction

    // view position the next in-order segment must start at
    function automatic logic [63:0] walk_pos();
        if (walk_idx < n_entries)
            return 64'(tbl_view[walk_idx]) + 64'(tbl_done[walk_idx]);
        return chain_end();
    endfunction

    function automatic logic [63:0] bytes_left();
        logic [osm_pkg::TOT_W-1:0] d;
        d = plan_bytes - seen_bytes;
        return 64'(d);
    endfunction

    function automatic logic [47:0] rand48();
        logic [31:0] lo, hi;
        lo = $urandom();
        hi = $urandom();
        return {hi[15:0], lo};
    endfunction

    task automatic send_item(logic [osm_pkg::FUNC_W-1:0] fn,
                             logic [osm_pkg::VOFF_W-1:0] voff,
                             logic [osm_pkg::LEN_W-1:0] len,
                             logic [osm_pkg::COFF_W-1:0] coff);
        while (feed_gaps && $urandom_range(0, 99) < 36) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {coff, len, voff};
        s_axis_tuser <= {6'b0, fn};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_mapping(fn, voff, len, coff);
        case (fn)
            osm_pkg::FUNC_LOAD:   n_load++;
            osm_pkg::FUNC_INGEST: n_ingest++;
            osm_pkg::FUNC_FINAL:  n_final++;
            default:              n_unused++;
        endcase
    endtask

    // nothing pending, then room for a walk that emits nothing
    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        while (expected_pieces.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_base(logic [63:0] value);
        wait_quiet();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        base_addr = value;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_after_chain(logic [osm_pkg::LEN_W-1:0] len);
        logic [63:0] pos;
        pos = chain_end();
        send_item(osm_pkg::FUNC_LOAD, pos[osm_pkg::VOFF_W-1:0], len, rand48());
    endtask

    task automatic ingest_in_order();
        logic [63:0] cap, rem_cur, seg, pos;
        int unsigned mode;
        cap = bytes_left();
        if (cap > 64'hFFFF_FFFF)
            cap = 64'hFFFF_FFFF;
        rem_cur = (walk_idx < n_entries) ?
                  64'(tbl_len[walk_idx]) - 64'(tbl_done[walk_idx]) : '0;
        mode = $urandom_range(0, 99);
        if (cap == 0) begin
            seg = $urandom_range(1, 16);
        end else begin
            if (mode < 40)
                seg = $urandom_range(1, 64);
            else if (mode < 65)
                seg = rem_cur;
            else if (mode < 85)
                seg = rem_cur + $urandom_range(1, 200);   // runs into the next descriptors
            else if (mode < 95)
                seg = $urandom();
            else
                seg = cap;
            if (seg == 0)
                seg = 1;
            if (seg > cap)
                seg = cap;
        end
        pos = walk_pos();
        send_item(osm_pkg::FUNC_INGEST, pos[osm_pkg::VOFF_W-1:0],
                  seg[osm_pkg::LEN_W-1:0], rand48());
    endtask

    task automatic ingest_out_of_order();
        logic [63:0] pos;
        logic [47:0] voff;
        int unsigned delta;
        pos = walk_pos();
        delta = $urandom_range(1, 64);
        if ($urandom_range(0, 1)) begin
            voff = rand48();
        end else if ($urandom_range(0, 1) && pos >= 64) begin
            voff = pos[47:0] - delta;
        end else begin
            voff = pos[47:0] + delta;
        end
        if (voff == pos[47:0])
            voff[0] = ~voff[0];
        send_item(osm_pkg::FUNC_INGEST, voff, $urandom(), rand48());
    endtask

    task automatic test_empty_table();
        send_item(osm_pkg::FUNC_INGEST, '0, 32'd5, rand48());
        send_item(osm_pkg::FUNC_INGEST, rand48(), '0, rand48());
        send_item(FUNC_UNUSED, rand48(), $urandom(), rand48());
    endtask

    task automatic test_first_descriptors();
        send_item(osm_pkg::FUNC_LOAD, 48'd0, 32'd8, '1);   // offset wraps with all-ones base
        send_item(osm_pkg::FUNC_LOAD, 48'd8, 32'd0, '0);   // empty descriptor
        send_item(osm_pkg::FUNC_LOAD, 48'd8, 32'd3, rand48());
        send_item(osm_pkg::FUNC_FINAL, rand48(), $urandom(), rand48());
    endtask

    task automatic test_ordering_errors();
        send_item(osm_pkg::FUNC_INGEST, 48'd0, 32'd4, rand48());
        send_item(osm_pkg::FUNC_INGEST, 48'd2, 32'd1, rand48());
        send_item(osm_pkg::FUNC_INGEST, 48'd9, 32'd1, rand48());
        send_item(osm_pkg::FUNC_INGEST, '1, '1, '1);
    endtask

    task automatic test_split_pieces();
        send_item(osm_pkg::FUNC_INGEST, 48'd4, 32'd6, rand48());
    endtask

    task automatic test_overrun_recovery();
        send_item(osm_pkg::FUNC_INGEST, 48'd10, 32'd5, rand48());
        send_item(osm_pkg::FUNC_LOAD, 48'd11, '1, rand48());
        send_item(osm_pkg::FUNC_INGEST, 48'd11, 32'd2, rand48());
        send_item(osm_pkg::FUNC_INGEST, 48'd13, 32'h100, rand48());
    endtask

    task automatic test_random_walk(int unsigned n_items, bit gaps);
        int unsigned sent, pick;
        feed_gaps = gaps;
        drain_gaps = gaps;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 12 && n_entries < 14) begin
                pick = $urandom_range(0, 9);
                if (pick < 1)
                    load_after_chain('0);
                else if (pick < 4)
                    load_after_chain($urandom_range(1, 32));
                else if (pick < 8)
                    load_after_chain($urandom_range(1, 4096));
                else
                    load_after_chain($urandom());
            end else if (pick < 62) begin
                ingest_in_order();
            end else if (pick < 84) begin
                ingest_out_of_order();
            end else if (pick < 88) begin
                send_item(osm_pkg::FUNC_INGEST, rand48(), '0, rand48());
            end else if (pick < 94) begin
                // a successful finalize would close the block for the rest of the run
                if (bytes_left() != 0)
                    send_item(osm_pkg::FUNC_FINAL, rand48(), $urandom(), rand48());
                else
                    ingest_in_order();
            end else begin
                send_item(FUNC_UNUSED, rand48(), $urandom(), rand48());
                continue;
            end
            sent++;
        end
        feed_gaps = 1'b1;
        drain_gaps = 1'b1;
    endtask

    // fills the table, ending on an empty descriptor that breaks the chain
    task automatic test_gap_after_pieces();
        logic [63:0] pos, left, seg;
        while (n_entries < 14)
            load_after_chain($urandom_range(1, 32));
        load_after_chain($urandom_range(16, 256));
        while (bytes_left() > 64'h8000_0000) begin
            left = bytes_left() - 100;
            seg = (left > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : left;
            pos = walk_pos();
            send_item(osm_pkg::FUNC_INGEST, pos[osm_pkg::VOFF_W-1:0],
                      seg[osm_pkg::LEN_W-1:0], rand48());
        end
        pos = chain_end();
        if ($urandom_range(0, 1))
            pos = pos + $urandom_range(1, 1000);
        else
            pos = pos - $urandom_range(1, 7);
        send_item(osm_pkg::FUNC_LOAD, pos[osm_pkg::VOFF_W-1:0], '0, rand48());
        pos = walk_pos();
        seg = bytes_left() + $urandom_range(1, 50);
        send_item(osm_pkg::FUNC_INGEST, pos[osm_pkg::VOFF_W-1:0],
                  seg[osm_pkg::LEN_W-1:0], rand48());
        pos = walk_pos();
        send_item(osm_pkg::FUNC_INGEST, pos[osm_pkg::VOFF_W-1:0], 32'd5, rand48());
    endtask

    task automatic test_full_table_and_close();
        send_item(osm_pkg::FUNC_LOAD, '1, '1, '1);
        send_item(osm_pkg::FUNC_FINAL, '0, '0, '0);
        send_item(osm_pkg::FUNC_INGEST, rand48(), $urandom(), rand48());
        send_item(osm_pkg::FUNC_LOAD, rand48(), $urandom(), rand48());
        send_item(osm_pkg::FUNC_FINAL, rand48(), $urandom(), rand48());
        send_item(FUNC_UNUSED, '1, '1, '1);
    endtask

    always @(posedge i_clk)
        m_axis_tready <= (drain_gaps && $urandom_range(0, 99) < 36) ? 1'b0 : 1'b1;

    always @(posedge i_clk) begin
        osm_pkg::t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = osm_pkg::t_status'(m_axis_tuser[osm_pkg::STAT_W-1:0]);
            got.dest = m_axis_tdata[63:0];
            got.plen = m_axis_tdata[95:64];
            got.soff = m_axis_tdata[127:96];
            got.last = m_axis_tlast;
            results_checked++;
            if (expected_pieces.size() == 0) begin
                if (error_count < 10)
                    $display("unexpected result: st=%0d dest=%h len=%h soff=%h last=%b",
                             got.status, got.dest, got.plen, got.soff, got.last);
                error_count++;
            end else begin
                want = expected_pieces.pop_front();
                if (got.status != want.status || got.dest != want.dest ||
                    got.plen != want.plen || got.soff != want.soff ||
                    got.last != want.last) begin
                    if (error_count < 10) begin
                        $display("mismatch: exp st=%0d dest=%h len=%h soff=%h last=%b",
                                 want.status, want.dest, want.plen, want.soff, want.last);
                        $display("          got st=%0d dest=%h len=%h soff=%h last=%b",
                                 got.status, got.dest, got.plen, got.soff, got.last);
                    end
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles", quiet_cycles);
                $display("testbench: errors");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= '0;
        feed_gaps = 1'b1;
        drain_gaps = 1'b1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_base('1);
        test_empty_table();
        test_first_descriptors();
        test_ordering_errors();
        test_split_pieces();
        test_overrun_recovery();
        write_base({$urandom(), $urandom()});
        test_random_walk(45, 1'b1);
        write_base('0);
        test_random_walk(45, 1'b0);
        write_base({$urandom(), $urandom()});
        test_random_walk(45, 1'b1);
        write_base('1);
        test_gap_after_pieces();
        test_full_table_and_close();
        wait_quiet();

        $display("run: %0d loads, %0d ingests, %0d finalize and %0d ignored items",
                 n_load, n_ingest, n_final, n_unused);
        $display("run: %0d results checked over %0d descriptors", results_checked, n_entries);
        if (error_count == 0 && expected_pieces.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("%0d failures, %0d results still expected",
                     error_count, expected_pieces.size());
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/osm_pkg.sv
hw/rtl/osm_desc_ram.sv
hw/rtl/osm_walker.sv
hw/rtl/ordered_segment_scatter_mapper_unit.sv
tb/testbench.sv
